>>> rtl/core/i2af_pkg.sv
// Shared types, codes and character tables of the integer to ASCII formatter.
package i2af_pkg;

    // Width of the running character count (wraps)
    localparam int COUNT_BITS = 32;

    // Digit store: up to 16 hex digits of a 64-bit pointer
    localparam int DIG_MAX   = 16;
    localparam int DIG_IDX_W = $clog2(DIG_MAX);
    localparam int POS_W     = 5;          // holds text lengths up to 18

    // Conversion kinds
    localparam logic [2:0] KIND_SDEC = 3'd0;
    localparam logic [2:0] KIND_UDEC = 3'd1;
    localparam logic [2:0] KIND_LHEX = 3'd2;
    localparam logic [2:0] KIND_UHEX = 3'd3;
    localparam logic [2:0] KIND_PTR  = 3'd4;

    // Reciprocal of ten for a 32-bit dividend, used with a shift of 35
    localparam logic [31:0] RECIP10       = 32'hCCCC_CCCD;
    localparam int          RECIP10_SHIFT = 35;

    // ASCII characters
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_X      = 8'h78;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_I      = 8'h69;
    localparam logic [7:0] CH_L      = 8'h6C;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LA     = 8'h61;   // 'a'
    localparam logic [7:0] CH_UA     = 8'h41;   // 'A'

    // Length of the text written for a null pointer
    localparam logic [POS_W-1:0] NIL_LEN = 5'd5;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;     // capture a new request
        logic step;     // extract one digit
        logic adv;      // advance to the next character
    } i2af_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic kind_ok;  // incoming kind is known
        logic nil;      // incoming request is a null pointer
        logic ext_done; // digit being extracted is the last one
        logic emit_last;// current character ends the text
    } i2af_sts_t;

    // Map a digit to its character
    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
        logic [7:0] base;
        base = upper ? CH_UA : CH_LA;
        if (d < 4'd10) begin
            digit_char = CH_ZERO + 8'(d);
        end else begin
            digit_char = base + 8'(d - 4'd10);
        end
    endfunction

    // Characters of "(nil)"
    function automatic logic [7:0] nil_char(input logic [2:0] p);
        case (p)
            3'd0:    nil_char = CH_LPAREN;
            3'd1:    nil_char = CH_N;
            3'd2:    nil_char = CH_I;
            3'd3:    nil_char = CH_L;
            default: nil_char = CH_RPAREN;
        endcase
    endfunction

endpackage

>>> rtl/core/integer_to_ascii_formatter_core.sv
// A request is captured, then the extractor produces its digits (1 to 16) one at a time,
// then one character per cycle goes out while m_tready is high; "(nil)" skips extraction.
// A new request is taken only after the previous text has gone out: the single shared
// divide-by-ten / shift unit and the one-character-per-cycle output serve one at a time.
// Reset: synchronous, active low; returns the controller to idle and clears the count.
// Top level of the integer to ASCII formatter.
module integer_to_ascii_formatter_core
    import i2af_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [63:0] value
    input  logic [2:0]  s_tuser,   // [2:0] func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [7:0] ch, [39:8] total
    output logic        m_tlast
);

    i2af_cmd_t cmd;
    i2af_sts_t sts;

    i2af_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    i2af_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .cmd     (cmd),
        .sts     (sts),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    // One request at a time: never take input while text is going out
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("input taken while text is being emitted");

    // Text continues after a character that is not the last
    a_text_continues: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !m_tlast) |=> m_tvalid)
        else $error("text ended without a last character");

    // Running total steps by one between consecutive characters
    a_total_steps: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready) |=>
            (!m_tvalid || (m_tdata[39:8] == $past(m_tdata[39:8]) + 32'd1)))
        else $error("running total did not advance by one");

endmodule

>>> rtl/core/i2af_ctrl.sv
// Controller state machine of the formatter: capture, extract digits, emit text.
module i2af_ctrl
    import i2af_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    output logic      m_tvalid,
    input  logic      m_tready,
    input  i2af_sts_t sts,
    output i2af_cmd_t cmd
);

    localparam logic [1:0] ST_IDLE    = 2'd0;
    localparam logic [1:0] ST_EXTRACT = 2'd1;
    localparam logic [1:0] ST_EMIT    = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid && sts.kind_ok) begin
                    cmd.load   = 1'b1;
                    state_next = sts.nil ? ST_EMIT : ST_EXTRACT;
                end
            end
            ST_EXTRACT: begin
                cmd.step = 1'b1;
                if (sts.ext_done) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                m_tvalid = 1'b1;
                if (m_tready) begin
                    cmd.adv = 1'b1;
                    if (sts.emit_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold the state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

>>> rtl/core/i2af_dp.sv
// Datapath of the formatter: value register, digit extractor, digit store, text mux, count.
module i2af_dp
    import i2af_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [63:0] s_tdata,
    input  logic [2:0]  s_tuser,
    input  i2af_cmd_t   cmd,
    output i2af_sts_t   sts,
    output logic [39:0] m_tdata,
    output logic        m_tlast
);

    logic [2:0]            kind_reg;
    logic                  nil_reg;
    logic [1:0]            plen_reg;
    logic [63:0]           val_reg;
    logic [POS_W-1:0]      ndig_reg;
    logic [POS_W-1:0]      pos_reg;
    logic [3:0]            digit_reg [DIG_MAX];
    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] count_next;

    logic                  in_neg;
    logic                  in_nil;
    logic [31:0]           in_mag;
    logic                  is_dec;
    logic [63:0]           prod;
    logic [31:0]           q10;
    logic [31:0]           q10_x10;
    logic [63:0]           quot;
    logic [3:0]            dig;
    logic [POS_W-1:0]      len;
    logic [POS_W-1:0]      didx;
    logic [7:0]            ch;

    // Decode the incoming request
    assign in_neg = (s_tuser == KIND_SDEC) && s_tdata[31];
    assign in_nil = (s_tuser == KIND_PTR) && (s_tdata == 64'd0);
    assign in_mag = in_neg ? (32'd0 - s_tdata[31:0]) : s_tdata[31:0];

    // Divide by ten through the reciprocal, or by sixteen with a shift
    assign is_dec  = (kind_reg == KIND_SDEC) || (kind_reg == KIND_UDEC);
    assign prod    = 64'(val_reg[31:0]) * 64'(RECIP10);
    assign q10     = 32'(prod[63:RECIP10_SHIFT]);
    assign q10_x10 = (q10 << 3) + (q10 << 1);
    assign quot    = is_dec ? 64'(q10) : (val_reg >> 4);
    assign dig     = is_dec ? 4'(val_reg[31:0] - q10_x10) : val_reg[3:0];

    // Select the current character
    assign len  = nil_reg ? NIL_LEN : (POS_W'(plen_reg) + ndig_reg);
    assign didx = ndig_reg - POS_W'(1) - (pos_reg - POS_W'(plen_reg));
    always_comb begin
        if (nil_reg) begin
            ch = nil_char(pos_reg[2:0]);
        end else if (pos_reg < POS_W'(plen_reg)) begin
            if (kind_reg == KIND_PTR) begin
                ch = (pos_reg == '0) ? CH_ZERO : CH_X;
            end else begin
                ch = CH_MINUS;
            end
        end else begin
            ch = digit_char(digit_reg[didx[DIG_IDX_W-1:0]], kind_reg == KIND_UHEX);
        end
    end

    assign count_next = count_reg + COUNT_BITS'(1);

    // Status to the controller
    assign sts.kind_ok   = (s_tuser <= KIND_PTR);
    assign sts.nil       = in_nil;
    assign sts.ext_done  = (quot == 64'd0);
    assign sts.emit_last = (pos_reg == len - POS_W'(1));

    // Result request: ch in the low byte, running total above
    assign m_tdata = {32'(count_next), ch};
    assign m_tlast = sts.emit_last;

    // Capture the request, extract digits and advance the character position
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            kind_reg <= s_tuser;
            nil_reg  <= in_nil;
            plen_reg <= in_neg ? 2'd1 : (((s_tuser == KIND_PTR) && !in_nil) ? 2'd2 : 2'd0);
            val_reg  <= (s_tuser == KIND_PTR) ? s_tdata : 64'(in_mag);
            ndig_reg <= '0;
            pos_reg  <= '0;
        end else begin
            if (cmd.step) begin
                digit_reg[ndig_reg[DIG_IDX_W-1:0]] <= dig;
                ndig_reg <= ndig_reg + POS_W'(1);
                val_reg  <= quot;
            end
            if (cmd.adv) begin
                pos_reg <= pos_reg + POS_W'(1);
            end
        end
    end

    // Advance the running count on each delivered character
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cmd.adv) begin
            count_reg <= count_next;
        end
    end

endmodule

>>> tb/tb.sv
// Self-checking testbench for the integer to ASCII formatter core.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import i2af_pkg::*;

    // Kinds that the core must ignore
    localparam logic [2:0] KIND_RSVD_FIRST = 3'd5;
    localparam logic [2:0] KIND_RSVD_LAST  = 3'd7;

    localparam int IDLE_LIMIT   = 5000;  // cycles with no handshake on either side
    localparam int DRAIN_CYCLES = 60;    // checks an ignored request adds no text
    localparam int RAND_PHASES  = 4;
    localparam int PHASE_ITEMS  = 105;

    // One character as it should leave the core
    typedef struct {
        logic [7:0]  ch;
        logic        last;
        logic [31:0] total;
    } text_char_t;

    // Predicts the formatted text and checks each character against it
    class formatted_text_board;
        text_char_t          pending_chars[$];
        logic [7:0]          text_buf[$];
        logic [COUNT_BITS-1:0] chars_emitted;
        int                  mismatches;
        int                  chars_checked;

        function new();
            chars_emitted = '0;
            mismatches    = 0;
            chars_checked = 0;
        endfunction

        // Append the digits of v, most significant first
        function void put_digits(logic [63:0] v, int unsigned radix, bit upper);
            logic [7:0] rev[$];
            logic [3:0] d;
            do begin
                d = 4'(v % radix);
                if (d < 4'd10)
                    rev.push_front(8'h30 + 8'(d));
                else
                    rev.push_front((upper ? 8'h41 : 8'h61) + 8'(d) - 8'd10);
                v = v / radix;
            end while (v != 0);
            foreach (rev[i]) text_buf.push_back(rev[i]);
        endfunction

        // Work out the characters an accepted request produces
        function void note_request(logic [2:0] func, logic [63:0] value);
            logic [31:0] low;
            text_char_t  c;
            text_buf.delete();
            low = value[31:0];
            case (func)
                KIND_SDEC: begin
                    if (low[31]) begin
                        text_buf.push_back("-");
                        low = 32'd0 - low;
                    end
                    put_digits({32'd0, low}, 10, 1'b0);
                end
                KIND_UDEC: put_digits({32'd0, low}, 10, 1'b0);
                KIND_LHEX: put_digits({32'd0, low}, 16, 1'b0);
                KIND_UHEX: put_digits({32'd0, low}, 16, 1'b1);
                KIND_PTR: begin
                    if (value == 64'd0) begin
                        text_buf.push_back("(");
                        text_buf.push_back("n");
                        text_buf.push_back("i");
                        text_buf.push_back("l");
                        text_buf.push_back(")");
                    end else begin
                        text_buf.push_back("0");
                        text_buf.push_back("x");
                        put_digits(value, 16, 1'b0);
                    end
                end
                default: ;
            endcase
            foreach (text_buf[k]) begin
                chars_emitted = chars_emitted + 1'b1;
                c.ch    = text_buf[k];
                c.last  = (k == text_buf.size() - 1);
                c.total = chars_emitted[31:0];
                pending_chars.push_back(c);
            end
        endfunction

        // Compare one accepted character with the oldest expectation
        function void check_char(logic [7:0] ch, logic last, logic [31:0] total);
            text_char_t exp_c;
            if (pending_chars.size() == 0) begin
                $error("unexpected character %h (last %b, total %0d)", ch, last, total);
                mismatches++;
                return;
            end
            exp_c = pending_chars.pop_front();
            chars_checked++;
            if (ch !== exp_c.ch) begin
                $error("ch: expected %h, got %h", exp_c.ch, ch);
                mismatches++;
            end
            if (last !== exp_c.last) begin
                $error("last: expected %b, got %b", exp_c.last, last);
                mismatches++;
            end
            if (total !== exp_c.total) begin
                $error("total: expected %0d, got %0d", exp_c.total, total);
                mismatches++;
            end
        endfunction

        function int pending_count();
            return pending_chars.size();
        endfunction
    endclass

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata  = '0;    // [63:0] value
    logic [2:0]  s_tuser  = '0;    // [2:0] func
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;          // [7:0] ch, [39:8] total
    logic        m_tlast;

    formatted_text_board sb = new();

    bit no_idle = 1'b0;
    int ready_hold = 0;
    int idle_cycles = 0;
    int requests_sent = 0;
    int ignored_requests = 0;

    integer_to_ascii_formatter_core uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #10 aclk = ~aclk;

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // Values spread over all digit counts, with the awkward ones favoured
    function automatic logic [63:0] pick_value();
        logic [63:0] full;
        full = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return full;
            4, 5:       return full >> $urandom_range(0, 63);
            6:          return 64'($urandom_range(0, 20));
            7:          return {full[63:32], 32'h8000_0000};
            8:          return {full[63:32], 32'hFFFF_FFFF};
            default:    return {full[63:32], 32'd0};
        endcase
    endfunction

    // Offer one request and hold it until the core takes it
    task automatic send_request(input logic [2:0] func, input logic [63:0] value);
        int gap;
        gap = no_idle ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= value;
        do @(posedge aclk); while (!s_tready);
        sb.note_request(func, value);
        requests_sent++;
        if (func > KIND_PTR) ignored_requests++;
    endtask

    // Check each character and stall the result side at random
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready)
                sb.check_char(m_tdata[7:0], m_tlast, m_tdata[39:8]);
            if (no_idle) begin
                m_tready   <= 1'b1;
                ready_hold = 0;
            end else if (ready_hold > 0) begin
                ready_hold = ready_hold - 1;
            end else begin
                m_tready   <= ($urandom_range(0, 99) < 65);
                ready_hold = pick_gap();
            end
        end
    end

    // Drop the run if nothing moves for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no request or character moved for %0d cycles", IDLE_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        logic [2:0] func;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: field extremes, every kind and the special cases
        send_request(KIND_SDEC, 64'd0);
        send_request(KIND_SDEC, 64'd1);
        send_request(KIND_SDEC, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(KIND_SDEC, 64'h0000_0000_8000_0000);
        send_request(KIND_SDEC, 64'h1234_5678_7FFF_FFFF);
        send_request(KIND_SDEC, 64'hFFFF_FFFF_0000_0000);
        send_request(KIND_UDEC, 64'd0);
        send_request(KIND_UDEC, 64'h0000_0000_FFFF_FFFF);
        send_request(KIND_UDEC, 64'hABCD_0000_8000_0000);
        send_request(KIND_LHEX, 64'd0);
        send_request(KIND_LHEX, 64'h0000_0000_DEAD_BEEF);
        send_request(KIND_LHEX, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(KIND_UHEX, 64'h5555_5555_ABCD_EF01);
        send_request(KIND_UHEX, 64'h0000_0000_FFFF_FFFF);
        send_request(KIND_PTR,  64'd0);
        send_request(KIND_PTR,  64'd1);
        send_request(KIND_PTR,  64'hFFFF_FFFF_FFFF_FFFF);
        send_request(KIND_PTR,  64'h0000_0001_0000_0000);
        send_request(KIND_PTR,  64'h8000_0000_0000_0000);
        send_request(KIND_RSVD_FIRST, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(3'd6, 64'd0);
        send_request(KIND_RSVD_LAST, 64'h0123_4567_89AB_CDEF);

        // Random phases, the second one without any idling
        for (int phase = 0; phase < RAND_PHASES; phase++) begin
            no_idle = (phase == 1);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(0, 99) < 8)
                    func = 3'($urandom_range(KIND_RSVD_FIRST, KIND_RSVD_LAST));
                else
                    func = 3'($urandom_range(KIND_SDEC, KIND_PTR));
                send_request(func, pick_value());
            end
        end
        no_idle = 1'b0;
        s_tvalid <= 1'b0;

        // Let the text drain, then allow for a trailing ignored request
        while (sb.pending_count() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Formatted %0d requests across all kinds, %0d of them ignored kinds,",
                 requests_sent, ignored_requests);
        $display("and checked %0d characters under random stalls on both sides.",
                 sb.chars_checked);
        if (sb.mismatches == 0 && sb.pending_count() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
